// ----- sv/hc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Hill cipher block.
package hc_pkg;

   localparam int DEF_MAX_BLOCK = 4;
   localparam int KEY_DIM       = 4;
   localparam int KEY_W         = 20;
   localparam int LETTER_W      = 5;
   localparam int BLK_SIZE_W    = 3;
   localparam int CSR_IDX_W     = 3;
   localparam int MOD_W         = 13;
   localparam int RECIP_SHIFT   = 20;

   localparam logic [15:0]         RECIP        = 16'd40330;
   localparam logic [4:0]          MODULUS      = 5'd26;
   localparam logic [LETTER_W-1:0] PAD_VALUE    = 5'd23;
   localparam logic [6:0]          LETTER_A     = 7'd65;
   localparam logic [7:0]          SPACE_CHAR   = 8'd32;
   localparam logic [7:0]          LOWER_A      = 8'd97;
   localparam logic [7:0]          LOWER_Z      = 8'd122;
   localparam logic [7:0]          CASE_OFFSET  = 8'd32;
   localparam logic [7:0]          LETTER_BIAS  = 8'd13;
   localparam logic [BLK_SIZE_W-1:0] BLK_SIZE_RESET = 3'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW3   = 3'd4;

   typedef struct packed {
      logic [7:0] char_in;
      logic       message_end;
   } hc_req_type;

   typedef struct packed {
      logic [6:0] cipher_char;
      logic       block_last;
      logic       message_last;
   } hc_rsp_type;

   // One output chain slot.
   typedef struct packed {
      logic                valid;
      logic [LETTER_W-1:0] letter;
      logic                block_last;
      logic                message_last;
   } hc_slot_type;

   typedef struct packed {
      logic load_sum;
      logic load_out;
      logic shift;
   } hc_ctrl_type;

   // x mod 26 by reciprocal multiply; exact for x below 2**MOD_W.
   function automatic logic [LETTER_W-1:0] mod26(input logic [MOD_W-1:0] x);
      logic [28:0]      prod;
      logic [MOD_W-1:0] q;
      logic [MOD_W-1:0] r;
      prod = 29'(x) * 29'(RECIP);
      q    = MOD_W'(prod >> RECIP_SHIFT);
      r    = x - MOD_W'(q * MOD_W'(MODULUS));
      return r[LETTER_W-1:0];
   endfunction

   // Key entries 26..31 fold back into 0..5.
   function automatic logic [LETTER_W-1:0] key_fold(input logic [LETTER_W-1:0] e);
      return (e >= MODULUS) ? e - MODULUS : e;
   endfunction

endpackage

// ----- sv/hc_front.sv -----
`timescale 1ns / 1ps
// Character intake: letter mapping, block buffer and padded block register.
module hc_front import hc_pkg::*; #(
   parameter int MAX_BLOCK = DEF_MAX_BLOCK,
   localparam int CNT_W = $clog2(MAX_BLOCK + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  hc_req_type            req_data,
   output logic                  req_stall,
   input  logic [BLK_SIZE_W-1:0] block_size,
   input  logic                  blk_take,
   output logic                  blk_valid,
   output logic [LETTER_W-1:0]   blk_vec [MAX_BLOCK],
   output logic [CNT_W-1:0]      blk_size,
   output logic                  blk_msg
);

   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [LETTER_W-1:0] letters_ff [MAX_BLOCK];
   logic [LETTER_W-1:0] letters_in [MAX_BLOCK];
   logic                p_valid_ff, p_valid_in;
   logic [LETTER_W-1:0] p_vec_ff [MAX_BLOCK];
   logic [LETTER_W-1:0] p_vec_in [MAX_BLOCK];
   logic [CNT_W-1:0]    p_size_ff;
   logic                p_msg_ff;

   logic [7:0]          ch_up;
   logic [LETTER_W-1:0] letter;
   logic                keep, store, emit, beat;
   logic [CNT_W-1:0]    eff_size, fill_new;

   assign req_stall = p_valid_ff && !blk_take;
   assign beat      = req_valid && !req_stall;

   always_comb begin
      keep  = req_data.char_in != SPACE_CHAR;
      ch_up = (req_data.char_in >= LOWER_A && req_data.char_in <= LOWER_Z) ?
              req_data.char_in - CASE_OFFSET : req_data.char_in;
      letter = mod26(MOD_W'(ch_up) + MOD_W'(LETTER_BIAS));

      if (block_size == '0) begin
         eff_size = CNT_W'(1);
      end else if (int'(block_size) > MAX_BLOCK) begin
         eff_size = CNT_W'(MAX_BLOCK);
      end else begin
         eff_size = CNT_W'(block_size);
      end

      store    = keep && (int'(fill_ff) < MAX_BLOCK);
      fill_new = store ? fill_ff + CNT_W'(1) : fill_ff;
      emit     = (fill_new >= eff_size) || (req_data.message_end && fill_new != '0);

      for (int i = 0; i < MAX_BLOCK; i++) begin
         letters_in[i] = (store && fill_ff == CNT_W'(i)) ? letter : letters_ff[i];
         if (CNT_W'(i) >= eff_size) begin
            p_vec_in[i] = '0;
         end else if (CNT_W'(i) < fill_new) begin
            p_vec_in[i] = letters_in[i];
         end else begin
            p_vec_in[i] = PAD_VALUE;
         end
      end

      fill_in = fill_ff;
      if (beat) begin
         fill_in = emit ? '0 : fill_new;
      end

      p_valid_in = p_valid_ff && !blk_take;
      if (beat && emit) begin
         p_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         p_valid_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat) begin
         letters_ff <= letters_in;
      end
      if (beat && emit) begin
         p_vec_ff  <= p_vec_in;
         p_size_ff <= eff_size;
         p_msg_ff  <= req_data.message_end;
      end
   end

   assign blk_valid = p_valid_ff;
   assign blk_vec   = p_vec_ff;
   assign blk_size  = p_size_ff;
   assign blk_msg   = p_msg_ff;

endmodule

// ----- sv/hc_cell.sv -----
`timescale 1ns / 1ps
// One key column: registered dot product, mod 26 reduction and output chain slot.
module hc_cell import hc_pkg::*; #(
   parameter int MAX_BLOCK  = DEF_MAX_BLOCK,
   parameter int CELL_INDEX = 0,
   localparam int CNT_W = $clog2(MAX_BLOCK + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  hc_ctrl_type         ctrl,
   input  logic [LETTER_W-1:0] vec_in [MAX_BLOCK],
   input  logic [KEY_W-1:0]    key_in [KEY_DIM],
   input  logic [CNT_W-1:0]    blk_size,
   input  logic                blk_msg,
   input  hc_slot_type         next_slot,
   output hc_slot_type         slot
);

   logic [LETTER_W-1:0] kcol [MAX_BLOCK];
   logic [MOD_W-1:0]    sum_ff, sum_in;
   hc_slot_type         slot_ff, slot_in;
   logic                is_last;

   for (genvar i = 0; i < MAX_BLOCK; i++) begin : g_kcol
      if (i < KEY_DIM && CELL_INDEX < KEY_DIM) begin : g_key
         assign kcol[i] = key_fold(key_in[i][LETTER_W*CELL_INDEX +: LETTER_W]);
      end else begin : g_zero
         assign kcol[i] = '0;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < MAX_BLOCK; i++) begin
         sum_in = sum_in + MOD_W'(vec_in[i]) * MOD_W'(kcol[i]);
      end

      is_last = blk_size == CNT_W'(CELL_INDEX + 1);
      slot_in = slot_ff;
      if (ctrl.load_out) begin
         slot_in.valid        = CNT_W'(CELL_INDEX) < blk_size;
         slot_in.letter       = mod26(sum_ff);
         slot_in.block_last   = is_last;
         slot_in.message_last = is_last && blk_msg;
      end else if (ctrl.shift) begin
         slot_in = next_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_sum) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.letter       <= slot_in.letter;
      slot_ff.block_last   <= slot_in.block_last;
      slot_ff.message_last <= slot_in.message_last;
   end

   assign slot = slot_ff;

endmodule

// ----- sv/hill_cipher_block.sv -----
`timescale 1ns / 1ps
// Hill cipher block, mod 26: top level with register file, control and cell row.
//
// Takes one text byte per cycle. Spaces are dropped, lower case is raised,
// every other byte becomes a letter value and is buffered until block_size
// letters are held (a message end pads a partial block with X). The block
// is multiplied by the key matrix in a row of column cells and leaves as
// block_size capital letters, shifted out of the cell row one per cycle while
// rsp_stall is low. With the row idle, the first letter of a block passes the
// block register, the sum stage and the head cell slot before rsp_valid shows it.
// Sustained rate is one character per cycle; a message end that flushes a
// short block yields block_size letters from one beat. The block register and
// the sum stage each hold one further block behind the cell row; once both
// are full the input stalls until the row empties. The input also stalls
// while rsp_stall holds the row. Configuration must be written only while the
// block is idle; the block does not enforce this, and csr_ready is always high.
module hill_cipher_block import hc_pkg::*; #(
   parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  hc_req_type           req_data,
   output logic                 req_stall,
   output logic                 rsp_valid,
   output hc_rsp_type           rsp_data,
   input  logic                 rsp_stall,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_data
);

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);

   logic [BLK_SIZE_W-1:0] block_size_ff;
   logic [KEY_W-1:0]      key_ff [KEY_DIM];

   logic                  blk_valid, blk_msg, blk_take;
   logic [LETTER_W-1:0]   blk_vec [MAX_BLOCK];
   logic [CNT_W-1:0]      blk_size;

   logic                  s_valid_ff, s_valid_in;
   logic [CNT_W-1:0]      s_size_ff;
   logic                  s_msg_ff;

   hc_slot_type           slot [MAX_BLOCK+1];
   hc_ctrl_type           ctrl;
   logic                  rsp_beat, chain_load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BLK_SIZE_RESET;
         for (int r = 0; r < KEY_DIM; r++) begin
            key_ff[r] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BLOCK_SIZE: block_size_ff <= csr_data[BLK_SIZE_W-1:0];
            CSR_KEY_ROW0:   key_ff[0] <= csr_data;
            CSR_KEY_ROW1:   key_ff[1] <= csr_data;
            CSR_KEY_ROW2:   key_ff[2] <= csr_data;
            CSR_KEY_ROW3:   key_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   hc_front #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .block_size (block_size_ff),
      .blk_take   (blk_take),
      .blk_valid  (blk_valid),
      .blk_vec    (blk_vec),
      .blk_size   (blk_size),
      .blk_msg    (blk_msg)
   );

   // Row reloads when empty or when its last letter leaves this cycle.
   assign rsp_beat   = slot[0].valid && !rsp_stall;
   assign chain_load = s_valid_ff && (!slot[0].valid || (!slot[1].valid && rsp_beat));
   assign blk_take   = blk_valid && (!s_valid_ff || chain_load);

   always_comb begin
      ctrl.load_sum = blk_take;
      ctrl.load_out = chain_load;
      ctrl.shift    = rsp_beat;
      s_valid_in    = blk_take || (s_valid_ff && !chain_load);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (blk_take) begin
         s_size_ff <= blk_size;
         s_msg_ff  <= blk_msg;
      end
   end

   assign slot[MAX_BLOCK] = '0;

   for (genvar j = 0; j < MAX_BLOCK; j++) begin : g_cell
      hc_cell #(
         .MAX_BLOCK  (MAX_BLOCK),
         .CELL_INDEX (j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .vec_in    (blk_vec),
         .key_in    (key_ff),
         .blk_size  (s_size_ff),
         .blk_msg   (s_msg_ff),
         .next_slot (slot[j+1]),
         .slot      (slot[j])
      );
   end

   assign rsp_valid             = slot[0].valid;
   assign rsp_data.cipher_char  = LETTER_A + 7'(slot[0].letter);
   assign rsp_data.block_last   = slot[0].block_last;
   assign rsp_data.message_last = slot[0].message_last;

`ifndef SYNTHESIS
   a_chain_packed: assert property (@(posedge clock) disable iff (reset)
      !slot[0].valid |-> !slot[1].valid)
      else $error("cell row has a gap at its head");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      chain_load |=> rsp_valid)
      else $error("row load produced no letter");

   a_msg_on_block_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.message_last |-> rsp_data.block_last)
      else $error("message end not on a block end");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !blk_valid |-> !req_stall)
      else $error("input stalled with empty block register");
`endif

endmodule

// ----- sim/tb_hill_cipher_block.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for hill_cipher_block: directed and random text against a cipher predictor.
module tb_hill_cipher_block;
   import hc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ERR_SHOWN   = 10;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   hc_req_type           req_data = '0;
   logic                 req_stall;
   logic                 rsp_valid;
   hc_rsp_type           rsp_data;
   logic                 rsp_stall = 1'b0;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [KEY_W-1:0]     csr_data = '0;

   // predictor state
   logic [BLK_SIZE_W-1:0] cfg_block_size;
   logic [KEY_W-1:0]      key_rows [KEY_DIM];
   int                    held_letters [DEF_MAX_BLOCK];
   int                    fill_level;
   hc_rsp_type            cipher_q [$];

   int          err_count = 0;
   int          char_count = 0;
   int          letter_count = 0;
   int          reg_writes = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   stall_mode_e stall_mode = STALL_NONE;
   int          stall_left = 0;

   hill_cipher_block dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d letters still expected",
                  cycle_count, cipher_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_e'($urandom_range(0, 3));
         stall_left <= $urandom_range(16, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
         STALL_PERIODIC: rsp_stall <= ((cycle_count % 7) < 3);
      endcase
   end

   task automatic log_error(input string msg);
      err_count++;
      if (err_count <= ERR_SHOWN) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      hc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         letter_count++;
         if (cipher_q.size() == 0) begin
            log_error($sformatf("unexpected letter %0d bl %0b ml %0b", rsp_data.cipher_char,
                                rsp_data.block_last, rsp_data.message_last));
         end else begin
            want = cipher_q.pop_front();
            if (rsp_data.cipher_char !== want.cipher_char ||
                rsp_data.block_last !== want.block_last ||
                rsp_data.message_last !== want.message_last)
               log_error($sformatf("expected char %0d bl %0b ml %0b, got char %0d bl %0b ml %0b",
                                   want.cipher_char, want.block_last, want.message_last,
                                   rsp_data.cipher_char, rsp_data.block_last,
                                   rsp_data.message_last));
         end
      end
   end

   function automatic int key_value(input int r, input int c);
      if (r >= KEY_DIM || c >= KEY_DIM) return 0;
      return int'((key_rows[r] >> (5 * c)) & 20'h1F) % 26;
   endfunction

   function automatic void predict_cipher(input hc_req_type item);
      logic [7:0] ch;
      int         n;
      int         acc;
      hc_rsp_type r;
      ch = item.char_in;
      n = (cfg_block_size == 0) ? 1 :
          (int'(cfg_block_size) > DEF_MAX_BLOCK) ? DEF_MAX_BLOCK : int'(cfg_block_size);
      if (ch != SPACE_CHAR) begin
         if (ch >= LOWER_A && ch <= LOWER_Z) ch = ch - CASE_OFFSET;
         if (fill_level < DEF_MAX_BLOCK) begin
            held_letters[fill_level] = (int'(ch) + 78 - 65) % 26;
            fill_level++;
         end
      end
      if (fill_level >= n || (item.message_end && fill_level > 0)) begin
         for (int i = fill_level; i < n; i++) held_letters[i] = int'(PAD_VALUE);
         for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int i = 0; i < n; i++) acc = (acc + held_letters[i] * key_value(i, j)) % 26;
            r.cipher_char  = 7'(65 + acc);
            r.block_last   = (j + 1 == n);
            r.message_last = (j + 1 == n) && item.message_end;
            cipher_q.push_back(r);
         end
         fill_level = 0;
      end
   endfunction

   task automatic send_char(input hc_req_type item);
      predict_cipher(item);
      char_count++;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_byte(input logic [7:0] ch, input logic msg_end);
      hc_req_type item;
      item.char_in     = ch;
      item.message_end = msg_end;
      send_char(item);
      pace();
   endtask

   task automatic send_text(input string s, input logic end_last);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], end_last && (i == s.len() - 1));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BLOCK_SIZE: cfg_block_size = value[BLK_SIZE_W-1:0];
         CSR_KEY_ROW0:   key_rows[0] = value;
         CSR_KEY_ROW1:   key_rows[1] = value;
         CSR_KEY_ROW2:   key_rows[2] = value;
         CSR_KEY_ROW3:   key_rows[3] = value;
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [BLK_SIZE_W-1:0] bs, input logic [KEY_W-1:0] k0,
                             input logic [KEY_W-1:0] k1, input logic [KEY_W-1:0] k2,
                             input logic [KEY_W-1:0] k3);
      wait_idle();
      write_reg(CSR_BLOCK_SIZE, KEY_W'(bs));
      write_reg(CSR_KEY_ROW0, k0);
      write_reg(CSR_KEY_ROW1, k1);
      write_reg(CSR_KEY_ROW2, k2);
      write_reg(CSR_KEY_ROW3, k3);
   endtask

   // reset key is all zero, so every letter comes out as A
   task automatic test_reset_config();
      send_text("ab", 1'b0);
   endtask

   task automatic test_char_extremes();
      set_config(3'd4, 20'h00001, 20'h00020, 20'h00400, 20'h08000);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("az", 1'b0);
      send_text("AZ {", 1'b1);
   endtask

   task automatic test_message_end();
      set_config(3'd3, 20'h6A3C1, 20'h1B2D7, 20'hF0E52, 20'h39C48);
      send_byte("Q", 1'b0);
      send_byte(SPACE_CHAR, 1'b1);
      send_byte(SPACE_CHAR, 1'b1);
      send_text("CAT", 1'b1);
      send_text("NO", 1'b1);
   endtask

   task automatic test_block_size_range();
      set_config(3'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      send_byte("K", 1'b0);
      set_config(3'd7, 20'hFFFFF, 20'h5A5A5, 20'hA5A5A, 20'h0F0F0);
      send_text("BIG", 1'b0);
      // shrink the block while three letters are held
      wait_idle();
      write_reg(CSR_BLOCK_SIZE, KEY_W'(3'd2));
      send_byte(SPACE_CHAR, 1'b0);
      send_byte("E", 1'b1);
   endtask

   task automatic test_random_traffic();
      logic [BLK_SIZE_W-1:0] sizes [6] = '{3'd1, 3'd4, 3'd0, 3'd3, 3'd7, 3'd2};
      logic [BLK_SIZE_W-1:0] bs;
      logic [KEY_W-1:0]      k [KEY_DIM];
      int                    start;
      int                    len;
      int                    pick;
      logic [7:0]            ch;
      for (int phase = 0; phase < 8; phase++) begin
         bs = (phase < 6) ? sizes[phase] : 3'($urandom_range(0, 7));
         for (int r = 0; r < KEY_DIM; r++)
            k[r] = (phase == 1) ? 20'hFFFFF : (phase == 3) ? 20'h00000 : KEY_W'($urandom);
         set_config(bs, k[0], k[1], k[2], k[3]);
         start = char_count;
         while (char_count - start < 14) begin
            if ($urandom_range(0, 6) == 0) begin
               send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
            end else begin
               len = $urandom_range(1, 12);
               for (int i = 0; i < len; i++) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 45)      ch = 8'("A" + $urandom_range(0, 25));
                  else if (pick < 80) ch = 8'("a" + $urandom_range(0, 25));
                  else if (pick < 92) ch = SPACE_CHAR;
                  else                ch = 8'($urandom_range(0, 255));
                  send_byte(ch, i == len - 1);
               end
            end
         end
      end
   endtask

   initial begin
      cfg_block_size = BLK_SIZE_RESET;
      for (int i = 0; i < KEY_DIM; i++) key_rows[i] = '0;
      for (int i = 0; i < DEF_MAX_BLOCK; i++) held_letters[i] = 0;
      fill_level = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_char_extremes();
      test_message_end();
      test_block_size_range();
      test_random_traffic();
      req_valid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      $display("Sent %0d characters over block sizes 0..7 and %0d register writes;",
               char_count, reg_writes);
      $display("checked %0d cipher letters under random sender gaps and receiver stalls.",
               letter_count);
      if (err_count == 0) $display("DONE: 0 errors");
      else                $display("DONE: errors detected");
      $finish;
   end

endmodule
